FILE: rtl/sckd_pkg.sv
// ----------------------------------------------------------------------------
// sckd_pkg
// Shared constants and types for the scan code key state decoder.
// ----------------------------------------------------------------------------
package sckd_pkg;

	// Stream widths
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;
	localparam int M_TUSER_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	// Map geometry
	localparam int MAP_DEPTH = 256;
	localparam int MAP_AW    = 8;
	localparam int CODE_W    = 8;

	// Default number of tracked button codes
	localparam int CODE_COUNT_DEF = 256;

	// Scan byte decoding
	localparam logic [7:0] EXT_PREFIX = 8'hE0;
	localparam logic [7:0] REL_MASK   = 8'h80;
	localparam logic [7:0] IDX_MASK   = 8'h7F;

	// Request kinds carried in s_tuser
	localparam logic CMD_SCAN = 1'b0;
	localparam logic CMD_MAP  = 1'b1;

	// Event kinds carried in m_tuser
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_DOWN = 2'd1;
	localparam logic [1:0] EV_UP   = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EVENTS_ENABLE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUMLOCK_CODE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CAPSLOCK_CODE = 2'd2;

	// One decoded result
	typedef struct packed {
		logic              unmapped_press;
		logic              led_update;
		logic              caps_lock;
		logic              num_lock;
		logic [CODE_W-1:0] button_code;
		logic [1:0]        event_kind;
	} result_t;

endpackage

FILE: rtl/scan_code_key_state_decoder.sv
// ----------------------------------------------------------------------------
// scan_code_key_state_decoder
// Set-1 scan byte decoder with a loadable code map and per-button key state.
// ----------------------------------------------------------------------------
// Channel  | Dir | Handshake          | Payload
// s_*      | in  | s_tvalid/s_tready  | s_tuser: cmd; s_tdata: scan_byte, map_index, map_code
// m_*      | out | m_tvalid/m_tready  | m_tuser: event_kind; m_tdata: button_code, locks, flags
// cfg_*    | in  | cfg_we             | cfg_index, cfg_data
//
// One request per cycle sustained while the skid slot is free; a result passes
// the map read, key state read, update and output register in that order.
// Key state read-modify-write is forwarded between neighboring requests.
// After reset a clearing pass zeroes both memories; s_tready is low during
// it. A two-entry output (register plus skid) lets the pipeline run while
// one result waits; the pipeline halts only when both are full.
// ----------------------------------------------------------------------------
module scan_code_key_state_decoder #(
	parameter int CODE_COUNT = sckd_pkg::CODE_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// slave side
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic                            s_tuser,  // [0] cmd
	input  logic [sckd_pkg::S_TDATA_W-1:0]  s_tdata,  // [7:0] scan_byte, [15:8] map_index,
	                                                  // [23:16] map_code
	// master side
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [sckd_pkg::M_TUSER_W-1:0]  m_tuser,  // [1:0] event_kind
	output logic [sckd_pkg::M_TDATA_W-1:0]  m_tdata,  // [7:0] button_code, [8] num_lock,
	                                                  // [9] caps_lock, [10] led_update,
	                                                  // [11] unmapped_press, rest zero
	// configuration
	input  logic                            cfg_we,
	input  logic [sckd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sckd_pkg::CFG_DAT_W-1:0]  cfg_data
);
	import sckd_pkg::*;

	localparam int KD_AW = (CODE_COUNT > 1) ? $clog2(CODE_COUNT) : 1;

	// Configuration registers
	logic              events_enable_q;
	logic [CODE_W-1:0] numlock_code_q;
	logic [CODE_W-1:0] capslock_code_q;

	// Clearing pass
	logic              clr_busy_q;
	logic [MAP_AW-1:0] clr_addr_q;

	// Memories
	logic [CODE_W-1:0] map_mem_q [MAP_DEPTH];
	logic              kd_mem_q  [CODE_COUNT];

	// Pipeline
	logic              en;
	logic              s_accept;
	logic              take_scan;
	logic              ext_q;
	logic [7:0]        scan_byte;
	logic [MAP_AW-1:0] map_index;
	logic [CODE_W-1:0] map_code;
	logic [MAP_AW-1:0] map_ra;
	logic              map_we;
	logic [MAP_AW-1:0] map_wa;
	logic [CODE_W-1:0] map_wd;

	logic              s1_valid_q;
	logic              rel_s1;
	logic [CODE_W-1:0] btn_s1;

	logic              s2_valid_q;
	logic              rel_s2;
	logic [CODE_W-1:0] btn_s2;
	logic              was_down_s2;

	logic              kd_we;
	logic [KD_AW-1:0]  kd_wa;
	logic              kd_wd;
	logic              s2_write;
	logic              rd_in_range;
	logic              s2_in_range;

	logic              num_q;
	logic              caps_q;
	logic              num_nxt;
	logic              caps_nxt;
	result_t           res;

	// Output register and skid
	logic              out_valid_q;
	result_t           out_q;
	logic              skid_valid_q;
	result_t           skid_q;

	// Field unpacking
	assign scan_byte = s_tdata[7:0];
	assign map_index = s_tdata[15:8];
	assign map_code  = s_tdata[23:16];

	// Advance the pipeline while the skid slot is free
	assign en        = !skid_valid_q;
	assign s_tready  = en && !clr_busy_q;
	assign s_accept  = s_tvalid && s_tready;
	assign take_scan = s_accept && (s_tuser == CMD_SCAN) && (scan_byte != EXT_PREFIX);

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			events_enable_q <= 1'b0;
			numlock_code_q  <= '0;
			capslock_code_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EVENTS_ENABLE: events_enable_q <= cfg_data[0];
				REG_NUMLOCK_CODE:  numlock_code_q  <= cfg_data[CODE_W-1:0];
				REG_CAPSLOCK_CODE: capslock_code_q <= cfg_data[CODE_W-1:0];
				default: ;
			endcase
		end
	end

	// Sweep both memories once after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == MAP_AW'(MAP_DEPTH - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Track the extended prefix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_q <= 1'b0;
		end else if (s_accept && s_tuser == CMD_SCAN) begin
			ext_q <= (scan_byte == EXT_PREFIX);
		end
	end

	// Map port selection: clearing pass or load request
	assign map_ra = (scan_byte & IDX_MASK) | (ext_q ? REL_MASK : 8'h00);
	always_comb begin
		map_we = 1'b0;
		map_wa = map_index;
		map_wd = map_code;
		if (clr_busy_q) begin
			map_we = 1'b1;
			map_wa = clr_addr_q;
			map_wd = '0;
		end else if (s_accept && s_tuser == CMD_MAP) begin
			map_we = 1'b1;
		end
	end

	// Code map memory
	always_ff @(posedge clk) begin
		if (map_we) begin
			map_mem_q[map_wa] <= map_wd;
		end
		if (en) begin
			btn_s1 <= map_mem_q[map_ra];
		end
	end

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (en) begin
			s1_valid_q <= take_scan;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rel_s1 <= (scan_byte & REL_MASK) != 8'h00;
		end
	end

	// Key state port: clearing pass or stage 2 write-back
	assign rd_in_range = {1'b0, btn_s1} < 9'(CODE_COUNT);
	assign s2_in_range = {1'b0, btn_s2} < 9'(CODE_COUNT);
	assign s2_write    = en && s2_valid_q && s2_in_range;

	always_comb begin
		kd_we = 1'b0;
		kd_wa = btn_s2[KD_AW-1:0];
		kd_wd = !rel_s2;
		if (clr_busy_q) begin
			kd_we = {1'b0, clr_addr_q} < 9'(CODE_COUNT);
			kd_wa = clr_addr_q[KD_AW-1:0];
			kd_wd = 1'b0;
		end else if (s2_write) begin
			kd_we = 1'b1;
		end
	end

	// Key state memory, write-first forwarding for a neighbor on the same code
	always_ff @(posedge clk) begin
		if (kd_we) begin
			kd_mem_q[kd_wa] <= kd_wd;
		end
		if (en) begin
			if (!rd_in_range) begin
				was_down_s2 <= 1'b0;
			end else if (s2_write && btn_s2 == btn_s1) begin
				was_down_s2 <= !rel_s2;
			end else begin
				was_down_s2 <= kd_mem_q[btn_s1[KD_AW-1:0]];
			end
		end
	end

	// Stage 2 control and payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (en) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rel_s2 <= rel_s1;
			btn_s2 <= btn_s1;
		end
	end

	// Decode the event and lock updates
	always_comb begin
		num_nxt  = num_q  ^ ((btn_s2 == numlock_code_q)  && !rel_s2);
		caps_nxt = caps_q ^ ((btn_s2 == capslock_code_q) && !rel_s2);
		res.event_kind = EV_NONE;
		if (events_enable_q) begin
			if (!was_down_s2 && !rel_s2) begin
				res.event_kind = EV_DOWN;
			end else if (was_down_s2 && rel_s2) begin
				res.event_kind = EV_UP;
			end
		end
		res.button_code    = btn_s2;
		res.num_lock       = num_nxt;
		res.caps_lock      = caps_nxt;
		res.led_update     = (btn_s2 == numlock_code_q) || (btn_s2 == capslock_code_q);
		res.unmapped_press = (btn_s2 == '0) && !rel_s2;
	end

	// Hold lock states
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q  <= 1'b0;
			caps_q <= 1'b0;
		end else if (en && s2_valid_q) begin
			num_q  <= num_nxt;
			caps_q <= caps_nxt;
		end
	end

	// Output register with skid slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (s2_valid_q) begin
			if (out_valid_q && !m_tready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (s2_valid_q) begin
			if (out_valid_q && !m_tready) begin
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.event_kind;
	assign m_tdata  = {4'b0000, out_q.unmapped_press, out_q.led_update,
	                   out_q.caps_lock, out_q.num_lock, out_q.button_code};

`ifndef SYNTHESIS
	// No request is taken while the memories are being cleared
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s_tready)
		else $error("request accepted during clearing pass");

	// A filled skid slot always sits behind a valid output
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid slot full with output empty");

	// Key state is never written back while the pipeline is halted
	a_no_write_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> !s2_write)
		else $error("key state written during stall");

	// A scan byte other than the prefix enters stage 1
	a_scan_enters: assert property (@(posedge clk) disable iff (!arst_n)
		take_scan |=> s1_valid_q)
		else $error("accepted scan byte lost before stage 1");

	// The clearing pass and a live stage 1 or stage 2 never overlap
	a_clear_pipe_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !s1_valid_q && !s2_valid_q)
		else $error("pipeline busy during clearing pass");
`endif

endmodule
